// File: rtl/sha256_stream_hasher_top_defines.svh
// Assertion macros shared by the SHA-256 stream hasher RTL.
`ifndef SHA256_STREAM_HASHER_TOP_DEFINES_SVH
`define SHA256_STREAM_HASHER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define SHS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SHS_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define SHS_ASSERT(lbl, prop, msg)
`define SHS_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// File: rtl/shs_pkg.sv
// Shared types, constants and functions of the SHA-256 stream hasher.
`default_nettype none
package shs_pkg;

	// Control of the block window
	typedef struct packed {
		logic shift_byte;
		logic shift_word;
	} win_ctl_t;

	// Control of the round core
	typedef struct packed {
		logic init_iv;
		logic start;
		logic step;
		logic add;
	} rnd_ctl_t;

	localparam logic [5:0] LAST_POS = 6'd63;
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam logic [5:0] LAST_RND = 6'd63;
	localparam logic [2:0] LAST_IDX = 3'd7;
	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [63:0] BITS_PER_BYTE = 64'd8;

	localparam logic [31:0] IV_TAB [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	localparam logic [31:0] K_TAB [64] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

	// Schedule sigma functions
	function automatic logic [31:0] sig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] sig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

	// Round sigma functions
	function automatic logic [31:0] big0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

endpackage
`default_nettype wire

// File: rtl/shs_window.sv
// Block window: byte fill buffer that doubles as the 16-word message schedule.
`default_nettype none
module shs_window (
	input  wire logic              clk,
	input  wire shs_pkg::win_ctl_t ctl,
	input  wire logic [7:0]        byte_in,
	output logic [31:0]            w_cur
);

	// Oldest byte sits in the top bits; word j is bits 511-32j down
	logic [511:0] win_q;
	logic [31:0]  w_new;

	// Next schedule word from taps t-16, t-15, t-7, t-2
	always_comb begin
		w_new = shs_pkg::sig1(win_q[63:32]) + win_q[223:192]
			+ shs_pkg::sig0(win_q[479:448]) + win_q[511:480];
	end

	assign w_cur = win_q[511:480];

	// Shift in bytes while filling, words while compressing
	always_ff @(posedge clk) begin
		if (ctl.shift_byte) begin
			win_q <= {win_q[503:0], byte_in};
		end else if (ctl.shift_word) begin
			win_q <= {win_q[479:0], w_new};
		end
	end

endmodule
`default_nettype wire

// File: rtl/shs_round.sv
// Round core: working variables, one compression round per cycle while stepping, hash words.
`default_nettype none
module shs_round (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire shs_pkg::rnd_ctl_t ctl,
	input  wire logic [5:0]        rnd,
	input  wire logic [31:0]       w_in,
	input  wire logic [2:0]        dig_idx,
	output logic [31:0]            digest_word
);

	logic [31:0] hash_q [8];
	logic [31:0] v_q [8];
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] ch;
	logic [31:0] maj;

	// Round function
	always_comb begin
		ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1  = v_q[7] + shs_pkg::big1(v_q[4]) + ch + shs_pkg::K_TAB[rnd] + w_in;
		t2  = shs_pkg::big0(v_q[0]) + maj;
	end

	// Load from hash words, then step the rounds
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= hash_q[i];
			end
		end else if (ctl.step) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	// Fold the block result into the hash words, or restart from the IV
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= shs_pkg::IV_TAB[i];
			end
		end else if (ctl.init_iv) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= shs_pkg::IV_TAB[i];
			end
		end else if (ctl.add) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= hash_q[i] + v_q[i];
			end
		end
	end

	assign digest_word = hash_q[dig_idx];

endmodule
`default_nettype wire

// File: rtl/sha256_stream_hasher_top.sv
// Top level of the SHA-256 stream hasher: sequencer, bit counter and result port.
//
//  channel  | signals                                      | moves
//  ---------+----------------------------------------------+------------------------
//  item     | item_valid, item_ready, command, data_byte   | one byte or a finish
//  result   | result_valid, result_ready, word_index,      | one digest word
//           | digest_word, last_word                       |
//
// A data byte is taken while idle; the 64th byte of a block starts a compression
// (64 rounds of the shared round core, then a fold into the hash words).
// A finish shifts in one padding byte per cycle up to the end of the block,
// runs one or two compressions, then offers eight words, one per cycle at best.
// item_ready is high only while no block, padding or digest is in progress.
// Reset loads the initial hash words and clears the fill and bit counts.
// The result port holds its word while result_ready is low.
`default_nettype none
`include "sha256_stream_hasher_top_defines.svh"
module sha256_stream_hasher_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic        command,
	input  wire logic [7:0]  data_byte,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [2:0]       word_index,
	output logic [31:0]      digest_word,
	output logic             last_word
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_COMP = 3'd1;
	localparam logic [2:0] S_ADD  = 3'd2;
	localparam logic [2:0] S_PAD  = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0]  state_q;
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [5:0]  rnd_q;
	logic        fin_q;
	logic        extra_q;
	logic        last_q;
	logic [2:0]  oidx_q;
	logic        ovalid_q;

	logic        acc_in;
	logic        acc_out;
	logic        shift_byte;
	logic        blk_full;
	logic [7:0]  byte_in;
	logic [7:0]  pad_byte;
	logic [63:0] len_sh;
	logic [31:0] w_cur;

	shs_pkg::win_ctl_t win_ctl;
	shs_pkg::rnd_ctl_t rnd_ctl;

	assign item_ready = (state_q == S_IDLE);
	assign acc_in     = item_valid & item_ready;
	assign acc_out    = ovalid_q & result_ready;

	// Pick the padding byte: zeros, or the big-endian bit count in the length block
	always_comb begin
		len_sh = bits_q >> {shs_pkg::LAST_IDX - fill_q[2:0], 3'b000};
		if (!extra_q && (fill_q >= shs_pkg::LEN_POS)) begin
			pad_byte = len_sh[7:0];
		end else begin
			pad_byte = 8'h00;
		end
	end

	// Drive the window and the round core
	always_comb begin
		shift_byte = acc_in | (state_q == S_PAD);
		blk_full   = shift_byte && (fill_q == shs_pkg::LAST_POS);
		if (acc_in) begin
			byte_in = command ? shs_pkg::PAD_MARK : data_byte;
		end else begin
			byte_in = pad_byte;
		end
		win_ctl.shift_byte = shift_byte;
		win_ctl.shift_word = (state_q == S_COMP);
		rnd_ctl.init_iv    = acc_out && (oidx_q == shs_pkg::LAST_IDX);
		rnd_ctl.start      = blk_full;
		rnd_ctl.step       = (state_q == S_COMP);
		rnd_ctl.add        = (state_q == S_ADD);
	end

	shs_window u_window (
		.clk     (clk),
		.ctl     (win_ctl),
		.byte_in (byte_in),
		.w_cur   (w_cur)
	);

	shs_round u_round (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (rnd_ctl),
		.rnd         (rnd_q),
		.w_in        (w_cur),
		.dig_idx     (oidx_q),
		.digest_word (digest_word)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= 6'd0;
			bits_q   <= 64'd0;
			rnd_q    <= 6'd0;
			fin_q    <= 1'b0;
			extra_q  <= 1'b0;
			last_q   <= 1'b0;
			oidx_q   <= 3'd0;
			ovalid_q <= 1'b0;
		end else begin
			// Advance the fill count on every byte into the window
			if (shift_byte) begin
				fill_q <= fill_q + 6'd1;
			end
			// Mark whether the finished block carries the bit count
			if (blk_full) begin
				if (state_q == S_PAD) begin
					last_q  <= ~extra_q;
					extra_q <= 1'b0;
				end else begin
					last_q <= 1'b0;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (acc_in) begin
						if (!command) begin
							bits_q <= bits_q + shs_pkg::BITS_PER_BYTE;
						end else begin
							fin_q   <= 1'b1;
							extra_q <= (fill_q >= shs_pkg::LEN_POS)
								&& (fill_q != shs_pkg::LAST_POS);
						end
						if (blk_full) begin
							state_q <= S_COMP;
						end else if (command) begin
							state_q <= S_PAD;
						end
					end
				end
				S_COMP: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == shs_pkg::LAST_RND) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					if (!fin_q) begin
						state_q <= S_IDLE;
					end else if (last_q) begin
						state_q  <= S_EMIT;
						ovalid_q <= 1'b1;
						oidx_q   <= 3'd0;
					end else begin
						state_q <= S_PAD;
					end
				end
				S_PAD: begin
					if (blk_full) begin
						state_q <= S_COMP;
					end
				end
				S_EMIT: begin
					// Drop the run after the last word is taken
					if (acc_out) begin
						if (oidx_q == shs_pkg::LAST_IDX) begin
							ovalid_q <= 1'b0;
							fin_q    <= 1'b0;
							last_q   <= 1'b0;
							bits_q   <= 64'd0;
							state_q  <= S_IDLE;
						end else begin
							oidx_q <= oidx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = ovalid_q;
	assign word_index   = oidx_q;
	assign last_word    = (oidx_q == shs_pkg::LAST_IDX);

	`SHS_ASSERT_NEVER(a_ready_no_result, item_ready && result_valid, "ready while emitting")
	`SHS_ASSERT(a_start_rnd0, rnd_ctl.start |=> (state_q == S_COMP) && (rnd_q == 6'd0), "bad start")
	`SHS_ASSERT(a_rounds_end, (state_q == S_COMP) && (rnd_q == shs_pkg::LAST_RND) |=> rnd_ctl.add, "no fold")
	`SHS_ASSERT(a_last_idle, acc_out && last_word |=> item_ready && (fill_q == 6'd0), "no restart")

endmodule
`default_nettype wire
